/* src/hierarchical_presence_bitmap_assert.svh */
// assertion macros for the presence bitmap
`ifndef HIERARCHICAL_PRESENCE_BITMAP_ASSERT_SVH
`define HIERARCHICAL_PRESENCE_BITMAP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HPB_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("hpb check failed");
`define HPB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("hpb check failed");
`else
`define HPB_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define HPB_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

/* src/hpb_pkg.sv */
`default_nettype none
package hpb_pkg;

  localparam int IDX_W     = 12;
  localparam int SCAN_BITS = 64;
  localparam int SCAN_W    = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FIND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_leaf;
    logic wr_leaf;
    logic rd_ends;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_hold;
  } ctrl_sts_t;

  function automatic logic [SCAN_W-1:0] low_bit(input logic [SCAN_BITS-1:0] w);
    logic [SCAN_W-1:0] r;
    r = '0;
    for (int i = SCAN_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = SCAN_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [SCAN_W-1:0] high_bit(input logic [SCAN_BITS-1:0] w);
    logic [SCAN_W-1:0] r;
    r = '0;
    for (int i = 0; i < SCAN_BITS; i++) begin
      if (w[i]) begin
        r = SCAN_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/hpb_in_if.sv */
`default_nettype none
interface hpb_in_if;
  import hpb_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] index;

  modport source (output valid, output mode, output index, input ready);
  modport sink (input valid, input mode, input index, output ready);
endinterface
`default_nettype wire

/* src/hpb_out_if.sv */
`default_nettype none
interface hpb_out_if;
  import hpb_pkg::*;

  logic             valid;
  logic             ready;
  logic             any_present;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] last_index;

  modport source (output valid, output any_present, output first_index,
                  output last_index, input ready);
  modport sink (input valid, input any_present, input first_index,
                input last_index, output ready);
endinterface
`default_nettype wire

/* src/hpb_ctrl.sv */
`default_nettype none
module hpb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hpb_pkg::ctrl_sts_t sts,
  output hpb_pkg::ctrl_cmd_t      cmd
);
  import hpb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_leaf = 1'b1;
        state_nxt   = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr_leaf = 1'b1;
        state_nxt   = ST_FIND;
      end
      ST_FIND: begin
        cmd.rd_ends = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_hold) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* src/hpb_datapath.sv */
`default_nettype none
module hpb_datapath #(
  parameter int ENTRIES   = 4096,
  parameter int WORD_BITS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire hpb_pkg::ctrl_cmd_t        cmd,
  output hpb_pkg::ctrl_sts_t             sts,
  input  wire logic                      in_mode,
  input  wire logic [hpb_pkg::IDX_W-1:0] in_index,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic                           out_any_present,
  output logic [hpb_pkg::IDX_W-1:0]      out_first_index,
  output logic [hpb_pkg::IDX_W-1:0]      out_last_index
);
  import hpb_pkg::*;

  localparam int LEAVES_RAW = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int LEAVES     = (LEAVES_RAW > SCAN_BITS) ? SCAN_BITS : LEAVES_RAW;
  localparam int LW         = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int OW         = $clog2(WORD_BITS);
  localparam int RK         = 20;
  localparam int RECIP      = ((1 << RK) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW         = IDX_W + RK + 1;

  // index split: quotient by reciprocal multiply, exact over the index range
  logic [PW-1:0]      prod;
  logic [IDX_W-1:0]   quot;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   quot_r;
  logic               mode_r;
  logic               ok_r;
  logic [LW-1:0]      leaf_r;
  logic [2*IDX_W-1:0] quot_w;
  logic [IDX_W-1:0]   rem;
  logic [OW-1:0]      off_r;

  assign prod   = PW'(in_index) * PW'(RECIP);
  assign quot   = prod[RK +: IDX_W];
  assign leaf_r = quot_r[LW-1:0];
  assign quot_w = (2*IDX_W)'(quot_r) * (2*IDX_W)'(WORD_BITS);
  assign rem    = idx_r - quot_w[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r  <= in_index;
      mode_r <= in_mode;
      quot_r <= quot;
      ok_r   <= ({1'b0, in_index} < (IDX_W + 1)'(ENTRIES)) &&
                ({1'b0, quot} < (IDX_W + 1)'(LEAVES));
    end
    if (cmd.rd_leaf) begin
      off_r <= rem[OW-1:0];
    end
  end

  // leaf store with per-leaf valid bits
  logic [WORD_BITS-1:0] mem [LEAVES];
  logic [LEAVES-1:0]    valid_r;
  logic [LEAVES-1:0]    summary_r;
  logic [WORD_BITS-1:0] rd_a_r;
  logic [WORD_BITS-1:0] rd_b_r;
  logic                 vld_a_r;
  logic                 vld_b_r;
  logic [LW-1:0]        fl;
  logic [LW-1:0]        hl;
  logic [LW-1:0]        fl_r;
  logic [LW-1:0]        hl_r;
  logic [LW-1:0]        addr_a;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] new_word;
  logic                 any_r;

  assign fl       = LW'(low_bit(SCAN_BITS'(summary_r)));
  assign hl       = LW'(high_bit(SCAN_BITS'(summary_r)));
  assign addr_a   = cmd.rd_ends ? fl : leaf_r;
  assign cur_word = vld_a_r ? rd_a_r : '0;
  assign bit_mask = WORD_BITS'(1) << off_r;
  assign new_word = mode_r ? (cur_word | bit_mask) : (cur_word & ~bit_mask);

  always_ff @(posedge clk) begin
    if (cmd.wr_leaf && ok_r) begin
      mem[leaf_r] <= new_word;
    end
    if (cmd.rd_leaf || cmd.rd_ends) begin
      rd_a_r  <= mem[addr_a];
      vld_a_r <= valid_r[addr_a];
      rd_b_r  <= mem[hl];
      vld_b_r <= valid_r[hl];
    end
    if (cmd.rd_ends) begin
      fl_r  <= fl;
      hl_r  <= hl;
      any_r <= |summary_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      summary_r <= '0;
    end else if (cmd.wr_leaf && ok_r) begin
      valid_r[leaf_r]   <= 1'b1;
      summary_r[leaf_r] <= |new_word;
    end
  end

  // end index assembly and output register
  logic [WORD_BITS-1:0] first_word;
  logic [WORD_BITS-1:0] last_word;
  logic [2*IDX_W-1:0]   first_base;
  logic [2*IDX_W-1:0]   last_base;
  logic [IDX_W-1:0]     first_idx;
  logic [IDX_W-1:0]     last_idx;
  logic                 out_valid_r;
  logic                 out_any_r;
  logic [IDX_W-1:0]     out_first_r;
  logic [IDX_W-1:0]     out_last_r;

  assign first_word = vld_a_r ? rd_a_r : '0;
  assign last_word  = vld_b_r ? rd_b_r : '0;
  assign first_base = (2*IDX_W)'(fl_r) * (2*IDX_W)'(WORD_BITS);
  assign last_base  = (2*IDX_W)'(hl_r) * (2*IDX_W)'(WORD_BITS);
  assign first_idx  = first_base[IDX_W-1:0] +
                      IDX_W'(low_bit(SCAN_BITS'(first_word)));
  assign last_idx   = last_base[IDX_W-1:0] +
                      IDX_W'(high_bit(SCAN_BITS'(last_word)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_any_r   <= any_r;
      out_first_r <= any_r ? first_idx : '0;
      out_last_r  <= any_r ? last_idx : '0;
    end
  end

  assign sts.out_hold    = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_any_present = out_any_r;
  assign out_first_index = out_first_r;
  assign out_last_index  = out_last_r;
endmodule
`default_nettype wire

/* src/hierarchical_presence_bitmap.sv */
// one transaction at a time: READ and WRITE do the leaf read-modify-write,
// FIND the summary search and the two end-leaf reads of the same store, and
// OUT loads the output register unless an untaken result is held there
// reset: synchronous active low; clears control, leaf valid bits and summary
// at once, no clearing pass
`default_nettype none
`include "hierarchical_presence_bitmap_assert.svh"
module hierarchical_presence_bitmap #(
  parameter int ENTRIES   = 4096,
  parameter int WORD_BITS = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hpb_in_if.sink    in_ch,
  hpb_out_if.source out_ch
);
  import hpb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  hpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpb_datapath #(
    .ENTRIES   (ENTRIES),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_ch.mode),
    .in_index        (in_ch.index),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_any_present (out_ch.any_present),
    .out_first_index (out_ch.first_index),
    .out_last_index  (out_ch.last_index)
  );

  `HPB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `HPB_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load_out, out_ch.valid)
  `HPB_ASSERT_SAME(a_empty_zero, clk, rst_n, out_ch.valid && !out_ch.any_present,
    out_ch.first_index == '0 && out_ch.last_index == '0)
  `HPB_ASSERT_SAME(a_order, clk, rst_n, out_ch.valid && out_ch.any_present,
    out_ch.first_index <= out_ch.last_index)
endmodule
`default_nettype wire

/* bench/hpb_map_check.sv */
`timescale 1ns / 1ps
module hpb_map_check (
  input  wire logic clk,
  input  wire logic rst_n,
  hpb_in_if         in_ch,
  hpb_out_if        out_ch,
  output int        mismatches,
  output int        pending
);
  import hpb_pkg::*;

  localparam int MAP_SIZE  = 4096;
  localparam int LEAF_BITS = 64;
  localparam int LEAVES    = 64;

  typedef struct packed {
    logic             any_present;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } map_report_t;

  logic [LEAF_BITS-1:0] leaf_map [LEAVES];
  logic [LEAVES-1:0]    busy_leaves;
  map_report_t          report_q [$];
  int                   err_count;

  function automatic int lowest_set(input logic [63:0] w);
    int n;
    n = 0;
    while (n < 63 && !w[n]) n++;
    return n;
  endfunction

  function automatic int highest_set(input logic [63:0] w);
    int n;
    n = 63;
    while (n > 0 && !w[n]) n--;
    return n;
  endfunction

  function automatic map_report_t apply_mark(input logic mode, input logic [IDX_W-1:0] index);
    map_report_t r;
    int leaf;
    int bit_pos;
    int lo_leaf;
    int hi_leaf;
    leaf    = int'(index) / LEAF_BITS;
    bit_pos = int'(index) % LEAF_BITS;
    if (int'(index) < MAP_SIZE && leaf < LEAVES) begin
      if (mode) begin
        leaf_map[leaf][bit_pos] = 1'b1;
        busy_leaves[leaf]       = 1'b1;
      end else begin
        leaf_map[leaf][bit_pos] = 1'b0;
        if (leaf_map[leaf] == '0) begin
          busy_leaves[leaf] = 1'b0;
        end
      end
    end
    r = '0;
    if (busy_leaves != '0) begin
      lo_leaf       = lowest_set(busy_leaves);
      hi_leaf       = highest_set(busy_leaves);
      r.any_present = 1'b1;
      r.first_index = IDX_W'(lo_leaf * LEAF_BITS + lowest_set(leaf_map[lo_leaf]));
      r.last_index  = IDX_W'(hi_leaf * LEAF_BITS + highest_set(leaf_map[hi_leaf]));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    map_report_t want;
    if (!rst_n) begin
      for (int i = 0; i < LEAVES; i++) begin
        leaf_map[i] = '0;
      end
      busy_leaves = '0;
      report_q.delete();
      err_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: unexpected transaction any=%0b first=%0d last=%0d", $realtime,
                     out_ch.any_present, out_ch.first_index, out_ch.last_index);
          end
        end else begin
          want = report_q.pop_front();
          if (out_ch.any_present !== want.any_present ||
              out_ch.first_index !== want.first_index ||
              out_ch.last_index !== want.last_index) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: expected any=%0b first=%0d last=%0d, got any=%0b first=%0d last=%0d",
                       $realtime, want.any_present, want.first_index, want.last_index,
                       out_ch.any_present, out_ch.first_index, out_ch.last_index);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        report_q.push_back(apply_mark(in_ch.mode, in_ch.index));
      end
    end
    pending    <= report_q.size();
    mismatches <= err_count;
  end

endmodule

/* bench/tb_hierarchical_presence_bitmap.sv */
`timescale 1ns / 1ps
module tb_hierarchical_presence_bitmap;
  import hpb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 140;
  localparam logic MARK_SET   = 1'b1;
  localparam logic MARK_CLEAR = 1'b0;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  bit   steady = 1'b0;
  int   marked [$];

  hpb_in_if  in_ch ();
  hpb_out_if out_ch ();

  hierarchical_presence_bitmap DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hpb_map_check u_map_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int p;
    int leaf;
    int bit_pos;
    p = $urandom_range(0, 99);
    if (p < 40) return IDX_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 3))
      0: leaf = 0;
      1: leaf = 63;
      2: leaf = 31;
      default: leaf = $urandom_range(0, 63);
    endcase
    p = $urandom_range(0, 3);
    bit_pos = (p == 0) ? 0 : (p == 1) ? 63 : $urandom_range(0, 63);
    return IDX_W'(leaf * 64 + bit_pos);
  endfunction

  task automatic send(input logic mode, input logic [IDX_W-1:0] index);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.index <= index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random(input int set_pct);
    int pos;
    logic [IDX_W-1:0] idx;
    if ($urandom_range(0, 99) < set_pct) begin
      idx = pick_index();
      marked.push_back(int'(idx));
      send(MARK_SET, idx);
    end else if (marked.size() > 0 && $urandom_range(0, 99) < 80) begin
      pos = $urandom_range(0, marked.size() - 1);
      idx = IDX_W'(marked[pos]);
      marked.delete(pos);
      send(MARK_CLEAR, idx);
    end else begin
      send(MARK_CLEAR, pick_index());
    end
  endtask

  // receiver: bursts of ready with random stalls in between
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int set_pct;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MARK_CLEAR;
    in_ch.index <= '0;
    rst_n       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // clear on empty map, then extremes and leaf boundaries
    send(MARK_CLEAR, 12'd5);
    send(MARK_SET, 12'd0);
    send(MARK_SET, 12'd4095);
    send(MARK_SET, 12'd63);
    send(MARK_SET, 12'd64);
    send(MARK_CLEAR, 12'd0);
    send(MARK_CLEAR, 12'd63);
    send(MARK_SET, 12'd4032);
    send(MARK_CLEAR, 12'd4095);
    send(MARK_CLEAR, 12'd100);
    send(MARK_CLEAR, 12'd64);
    send(MARK_CLEAR, 12'd4032);
    send(MARK_SET, 12'd2047);
    send(MARK_SET, 12'd2048);
    send(MARK_SET, 12'd2047);
    send(MARK_CLEAR, 12'd2047);
    send(MARK_SET, 12'd1365);
    send(MARK_SET, 12'd2730);
    send(MARK_CLEAR, 12'd2048);
    send(MARK_CLEAR, 12'd1365);
    send(MARK_CLEAR, 12'd2730);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      steady  = (ph == 2);
      set_pct = (ph == 0) ? 80 : (ph == 2) ? 50 : 20;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_random(set_pct);
      end
      wait_idle();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/hpb_pkg.sv
src/hpb_in_if.sv
src/hpb_out_if.sv
src/hpb_ctrl.sv
src/hpb_datapath.sv
src/hierarchical_presence_bitmap.sv
bench/hpb_map_check.sv
bench/tb_hierarchical_presence_bitmap.sv
